FILE: design/frbws_pkg.sv
// Shared types and constants of the frame rate blend weight scheduler.
package frbws_pkg;

	localparam int unsigned PERIOD_W = 32;
	localparam int unsigned OFFSET_W = 33;
	localparam int unsigned WEIGHT_W = 8;
	localparam int unsigned NUM_W    = PERIOD_W + WEIGHT_W;
	localparam int unsigned STEP_W   = 3;

	localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 8'hFF;

	localparam logic CFG_INPUT_PERIOD  = 1'b0;
	localparam logic CFG_OUTPUT_PERIOD = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LIMIT,
		ST_CHECK,
		ST_DIFF,
		ST_SCALE,
		ST_DIV,
		ST_EMIT,
		ST_ERR
	} state_t;

endpackage

FILE: design/frame_rate_blend_weight_scheduler.sv
// Top level: blend weight sequencer with a serial divider.
//
//  channel   direction  handshake              payload
//  in        sink       in_valid / in_ready    end_of_source
//  out       source     out_valid / out_ready  weight_older, weight_newer, output_index,
//                                              window_index, last_of_run, config_error
//  cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item has its periods checked in the limit and check states; each result then takes an offset
// compare, a scale by 255, eight restoring divide steps and an emit, and a final offset compare
// closes the window.
// in_ready is high only while the sequencer is idle; cfg_ready is always high.
// A stalled output holds the sequencer in its emit state; reset initialises the control registers only.
module frame_rate_blend_weight_scheduler #(
	parameter int unsigned MAX_RUN = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        end_of_source,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  weight_older,
	output logic [7:0]  weight_newer,
	output logic [31:0] output_index,
	output logic [31:0] window_index,
	output logic        last_of_run,
	output logic        config_error,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	import frbws_pkg::*;

	localparam int unsigned LIM_W = PERIOD_W + $clog2(MAX_RUN);
	localparam int unsigned RUN_W = $clog2(MAX_RUN + 1);

	state_t state_q, state_d;

	logic [PERIOD_W-1:0] input_period_q, output_period_q;
	logic                primed_q, finished_q, eos_q;
	logic [OFFSET_W-1:0] offset_q, nxt_q;
	logic [PERIOD_W-1:0] output_count_q, window_count_q;
	logic [RUN_W-1:0]    run_q;
	logic [LIM_W-1:0]    lim_q;
	logic [PERIOD_W-1:0] diff_q;
	logic [NUM_W-1:0]    rem_q;
	logic [WEIGHT_W-1:0] quo_q;
	logic [STEP_W-1:0]   step_q;
	logic                out_valid_q;

	logic                in_fire, out_free, out_load, cfg_fire;
	logic                bad_cfg, run_more;
	logic [NUM_W-1:0]    div_shift;
	logic [NUM_W:0]      div_cand;
	logic [OFFSET_W:0]   win_sub;
	logic                emit_last;

	assign in_fire  = in_valid && in_ready;
	assign cfg_fire = cfg_valid && cfg_ready;
	assign out_free = !out_valid_q || out_ready;

	assign bad_cfg = (input_period_q == '0) || (output_period_q == '0)
		|| (output_period_q > input_period_q)
		|| (LIM_W'(input_period_q) > lim_q);
	assign run_more = (offset_q <= OFFSET_W'(input_period_q)) && (run_q < RUN_W'(MAX_RUN));

	assign div_shift = NUM_W'(input_period_q) << step_q;
	assign div_cand  = {1'b0, rem_q} - {1'b0, div_shift};
	assign win_sub   = {1'b0, offset_q} - (OFFSET_W + 1)'(input_period_q);
	assign emit_last = (nxt_q > OFFSET_W'(input_period_q)) || (run_q == RUN_W'(MAX_RUN - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire && !finished_q) state_d = ST_LIMIT;
			end
			ST_LIMIT: state_d = ST_CHECK;
			ST_CHECK: begin
				if (bad_cfg) state_d = ST_ERR;
				else if (eos_q || !primed_q) state_d = ST_IDLE;
				else state_d = ST_DIFF;
			end
			ST_DIFF: begin
				if (run_more) state_d = ST_SCALE;
				else state_d = ST_IDLE;
			end
			ST_SCALE: state_d = ST_DIV;
			ST_DIV: begin
				if (step_q == '0) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) state_d = ST_DIFF;
			end
			ST_ERR: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready  = 1'b0;
		out_load  = 1'b0;
		cfg_ready = 1'b1;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_EMIT, ST_ERR: out_load = out_free;
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			input_period_q  <= PERIOD_W'(1);
			output_period_q <= PERIOD_W'(1);
			primed_q        <= 1'b0;
			finished_q      <= 1'b0;
			offset_q        <= '0;
			output_count_q  <= '0;
			window_count_q  <= '0;
			run_q           <= '0;
			step_q          <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_fire) begin
				unique case (cfg_index)
					CFG_INPUT_PERIOD:  input_period_q  <= cfg_data;
					CFG_OUTPUT_PERIOD: output_period_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			unique case (state_q)
				ST_CHECK: begin
					if (!bad_cfg) begin
						if (eos_q) finished_q <= 1'b1;
						else if (!primed_q) primed_q <= 1'b1;
					end
					run_q <= '0;
				end
				ST_DIFF: begin
					if (!run_more) begin
						// window closes: carry the overshoot into the next one
						offset_q       <= win_sub[OFFSET_W] ? '0 : win_sub[OFFSET_W-1:0];
						window_count_q <= window_count_q + 1'b1;
					end
				end
				ST_SCALE: step_q <= STEP_W'(WEIGHT_W - 1);
				ST_DIV: step_q <= step_q - 1'b1;
				ST_EMIT: begin
					if (out_free) begin
						offset_q       <= nxt_q;
						run_q          <= run_q + 1'b1;
						output_count_q <= output_count_q + 1'b1;
					end
				end
				ST_ERR: begin
					if (out_free) finished_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// datapath and output payload
	always_ff @(posedge clk) begin
		if (in_fire) eos_q <= end_of_source;
		unique case (state_q)
			ST_LIMIT: lim_q <= LIM_W'(output_period_q) * LIM_W'(MAX_RUN - 1);
			ST_DIFF:  diff_q <= input_period_q - offset_q[PERIOD_W-1:0];
			ST_SCALE: begin
				// 255 * d as (d << 8) - d
				rem_q <= {diff_q, {WEIGHT_W{1'b0}}} - NUM_W'(diff_q);
				nxt_q <= offset_q + OFFSET_W'(output_period_q);
				quo_q <= '0;
			end
			ST_DIV: begin
				if (!div_cand[NUM_W]) begin
					rem_q <= div_cand[NUM_W-1:0];
					quo_q <= {quo_q[WEIGHT_W-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[WEIGHT_W-2:0], 1'b0};
				end
			end
			default: ;
		endcase
		if (out_load) begin
			output_index <= output_count_q;
			window_index <= window_count_q;
			if (state_q == ST_ERR) begin
				weight_older <= '0;
				weight_newer <= '0;
				last_of_run  <= 1'b1;
				config_error <= 1'b1;
			end else begin
				weight_older <= quo_q;
				weight_newer <= WEIGHT_FULL - quo_q;
				last_of_run  <= emit_last;
				config_error <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: design/frbws_checker.sv
// Port-level checker for the frame rate blend weight scheduler, with its bind.
module frbws_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  weight_older,
	input logic [7:0]  weight_newer,
	input logic [31:0] output_index,
	input logic        last_of_run,
	input logic        config_error
);
	import frbws_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(weight_older)
			&& $stable(output_index) && $stable(last_of_run) && $stable(config_error))
		else $error("result changed while stalled");

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && config_error |-> last_of_run && weight_older == '0 && weight_newer == '0)
		else $error("bad error result");

	a_weight_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !config_error |->
			({1'b0, weight_older} + {1'b0, weight_newer}) == {1'b0, WEIGHT_FULL})
		else $error("weights do not sum to full scale");

	a_stop_after_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && config_error |=> !out_valid)
		else $error("result after error");

endmodule

bind frame_rate_blend_weight_scheduler frbws_checker u_frbws_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.weight_older (weight_older),
	.weight_newer (weight_newer),
	.output_index (output_index),
	.last_of_run  (last_of_run),
	.config_error (config_error)
);
